>>> rtl/rbsi_pkg.sv
// Shared widths and types for the box slab intersection block.
`default_nettype none
package rbsi_pkg;
    localparam int CW       = 32;
    localparam int FRAC     = 16;
    localparam int NW       = CW + FRAC;
    localparam int TW       = NW + 2;
    localparam int OUT_W    = 31;
    localparam int IN_BITS  = 12 * CW;
    localparam int OUT_BITS = ((1 + 2 * OUT_W + 7) / 8) * 8;
    localparam int DEPTH    = NW + 4;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic par;
        logic miss;
    } axis_tag_t;
endpackage
`default_nettype wire

>>> rtl/rbsi_axis.sv
// One axis: slab distances by a bit-per-stage divider, ordered into near and far.
`default_nettype none
module rbsi_axis
    import rbsi_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 adv,
    input  wire logic signed [CW-1:0] org,
    input  wire logic signed [CW-1:0] dir,
    input  wire logic signed [CW-1:0] lo,
    input  wire logic signed [CW-1:0] hi,
    output logic signed [TW-1:0]      near_reg,
    output logic signed [TW-1:0]      far_reg,
    output logic                      miss_reg
);
    logic [NW-1:0] na_reg [0:NW];
    logic [NW-1:0] nb_reg [0:NW];
    logic [NW-1:0] qa_reg [0:NW];
    logic [NW-1:0] qb_reg [0:NW];
    logic [CW-1:0] ra_reg [0:NW];
    logic [CW-1:0] rb_reg [0:NW];
    logic [CW-1:0] d_reg  [0:NW];
    axis_tag_t     tag_reg[0:NW];

    logic signed [CW:0] da, db, ma, mb;
    logic [CW-1:0]      dmag;
    axis_tag_t          tag_next;

    always_comb begin
        da = {lo[CW-1], lo} - {org[CW-1], org};
        db = {hi[CW-1], hi} - {org[CW-1], org};
        ma = da[CW] ? -da : da;
        mb = db[CW] ? -db : db;
        dmag = dir[CW-1] ? (~dir + 1'b1) : dir;
        tag_next.par   = (dir == '0);
        tag_next.miss  = (dir == '0) && ((org < lo) || (hi < org));
        tag_next.neg_a = da[CW] ^ dir[CW-1];
        tag_next.neg_b = db[CW] ^ dir[CW-1];
        if (dir == '0) begin
            dmag = {{(CW-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            na_reg[0]  <= {ma[CW-1:0], {FRAC{1'b0}}};
            nb_reg[0]  <= {mb[CW-1:0], {FRAC{1'b0}}};
            qa_reg[0]  <= '0;
            qb_reg[0]  <= '0;
            ra_reg[0]  <= '0;
            rb_reg[0]  <= '0;
            d_reg[0]   <= dmag;
            tag_reg[0] <= tag_next;
        end
    end

    for (genvar i = 0; i < NW; i++) begin : g_step
        logic [CW:0] rsa, rsb, rna, rnb;
        logic        ga, gb;
        always_comb begin
            rsa = {ra_reg[i], na_reg[i][NW-1]};
            rsb = {rb_reg[i], nb_reg[i][NW-1]};
            ga  = rsa >= {1'b0, d_reg[i]};
            gb  = rsb >= {1'b0, d_reg[i]};
            rna = ga ? rsa - {1'b0, d_reg[i]} : rsa;
            rnb = gb ? rsb - {1'b0, d_reg[i]} : rsb;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                na_reg[i+1]  <= {na_reg[i][NW-2:0], 1'b0};
                nb_reg[i+1]  <= {nb_reg[i][NW-2:0], 1'b0};
                qa_reg[i+1]  <= {qa_reg[i][NW-2:0], ga};
                qb_reg[i+1]  <= {qb_reg[i][NW-2:0], gb};
                ra_reg[i+1]  <= rna[CW-1:0];
                rb_reg[i+1]  <= rnb[CW-1:0];
                d_reg[i+1]   <= d_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    logic signed [TW-1:0] sa, sb, near_next, far_next;

    always_comb begin
        sa = $signed({2'b00, qa_reg[NW]});
        sb = $signed({2'b00, qb_reg[NW]});
        if (tag_reg[NW].neg_a) sa = -sa;
        if (tag_reg[NW].neg_b) sb = -sb;
        if (tag_reg[NW].par) begin
            near_next = $signed({1'b1, {(TW-1){1'b0}}});
            far_next  = $signed({1'b0, {(TW-1){1'b1}}});
        end else if (sb < sa) begin
            near_next = sb;
            far_next  = sa;
        end else begin
            near_next = sa;
            far_next  = sb;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            near_reg <= near_next;
            far_reg  <= far_next;
            miss_reg <= tag_reg[NW].miss;
        end
    end
endmodule
`default_nettype wire

>>> rtl/ray_box_slab_intersect_top.sv
// Pipeline: input register, 48 divider stages, then the near/far, entry/exit and output registers.
// Throughput: one item per cycle; the whole pipeline holds while m_tready is low
// and the output register is full.
// Reset: aresetn synchronous active low clears all valid bits; data is not reset.
// Top level of the box slab intersection block.
`default_nettype none
module ray_box_slab_intersect_top
    import rbsi_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // org_x, org_y, org_z, dir_x, dir_y, dir_z, box_min_x..z, box_max_x..z
    input  wire logic [IN_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // hit, t_entry, t_exit, zero pad
    output logic [OUT_BITS-1:0]      m_tdata
);
    logic             adv;
    logic [DEPTH-1:0] v_reg;

    logic signed [TW-1:0] near_w [0:2];
    logic signed [TW-1:0] far_w  [0:2];
    logic                 miss_w [0:2];

    assign adv      = !v_reg[DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[DEPTH-2:0], s_tvalid};
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbsi_axis u_axis (
            .aclk     (aclk),
            .adv      (adv),
            .org      ($signed(s_tdata[a*CW +: CW])),
            .dir      ($signed(s_tdata[(3+a)*CW +: CW])),
            .lo       ($signed(s_tdata[(6+a)*CW +: CW])),
            .hi       ($signed(s_tdata[(9+a)*CW +: CW])),
            .near_reg (near_w[a]),
            .far_reg  (far_w[a]),
            .miss_reg (miss_w[a])
        );
    end

    logic signed [TW-1:0] tin, tout;
    logic signed [TW-1:0] tin_reg, tout_reg;
    logic                 miss_any_reg;
    logic                 ok;
    logic [OUT_W-1:0]     ent_next, ext_next;
    logic [OUT_BITS-1:0]  out_reg;

    always_comb begin
        tin  = '0;
        tout = $signed({1'b0, {(TW-1){1'b1}}});
        for (int a = 0; a < 3; a++) begin
            if (tin < near_w[a]) tin = near_w[a];
            if (far_w[a] < tout) tout = far_w[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tin_reg      <= tin;
            tout_reg     <= tout;
            miss_any_reg <= miss_w[0] || miss_w[1] || miss_w[2];
        end
    end

    always_comb begin
        ok = !miss_any_reg && !(tout_reg < tin_reg);
        ent_next = (tin_reg > $signed({{(TW-OUT_W){1'b0}}, {OUT_W{1'b1}}}))
                   ? {OUT_W{1'b1}} : tin_reg[OUT_W-1:0];
        if (tout_reg < 0) begin
            ext_next = '0;
        end else if (tout_reg > $signed({{(TW-OUT_W){1'b0}}, {OUT_W{1'b1}}})) begin
            ext_next = {OUT_W{1'b1}};
        end else begin
            ext_next = tout_reg[OUT_W-1:0];
        end
        if (!ok) begin
            ent_next = '0;
            ext_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= {{(OUT_BITS-1-2*OUT_W){1'b0}}, ext_next, ent_next, ok};
        end
    end

    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[2*OUT_W:1] == '0)
        else $error("miss item carries nonzero distances");
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[OUT_W:1] <= m_tdata[2*OUT_W:OUT_W+1])
        else $error("entry beyond exit on hit");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(v_reg))
        else $error("pipeline moved during stall");
`endif
endmodule
`default_nettype wire

>>> verif/ray_box_slab_intersect_top_test.sv
// Testbench for the box slab intersection block: directed and random boxes checked against a predictor.
`timescale 1ns / 100ps
module ray_box_slab_intersect_top_test;
    import rbsi_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [30:0] t_entry;
        logic [30:0] t_exit;
    } slab_res_t;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [127:0] dist_t;

    localparam int WATCH_LIMIT = 20000;
    localparam int PIPE_LAT    = 52;
    localparam dist_t POS_INF  = {1'b0, {127{1'b1}}};
    localparam dist_t NEG_INF  = {1'b1, {127{1'b0}}};
    localparam logic [30:0] DIST_MAX = 31'h7FFFFFFF;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;

    slab_res_t hit_queue[$];
    int        mismatches;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_stall_pct;

    ray_box_slab_intersect_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [30:0] clamp_dist(dist_t v);
        if (v < 0) return 31'd0;
        if (v > dist_t'(DIST_MAX)) return DIST_MAX;
        return v[30:0];
    endfunction

    function automatic slab_res_t predict_slab(coord_t c[12]);
        slab_res_t r;
        dist_t t_in, t_out, a, b, n, f, num, den;
        logic ok;
        t_in = 0;
        t_out = POS_INF;
        ok = 1'b1;
        for (int ax = 0; ax < 3; ax++) begin
            if (ok) begin
                if (c[3+ax] == 0) begin
                    if (c[ax] < c[6+ax] || c[9+ax] < c[ax]) ok = 1'b0;
                    n = NEG_INF;
                    f = POS_INF;
                end else begin
                    den = dist_t'(c[3+ax]);
                    num = (dist_t'(c[6+ax]) - dist_t'(c[ax])) <<< FRAC;
                    a = num / den;
                    num = (dist_t'(c[9+ax]) - dist_t'(c[ax])) <<< FRAC;
                    b = num / den;
                    if (b < a) begin
                        n = b;
                        f = a;
                    end else begin
                        n = a;
                        f = b;
                    end
                end
                if (ok) begin
                    if (t_in < n) t_in = n;
                    if (f < t_out) t_out = f;
                end
            end
        end
        if (ok && t_out < t_in) ok = 1'b0;
        r.hit = ok;
        r.t_entry = ok ? clamp_dist(t_in) : 31'd0;
        r.t_exit = ok ? clamp_dist(t_out) : 31'd0;
        return r;
    endfunction

    task automatic send_box(coord_t c[12]);
        logic [IN_BITS-1:0] d;
        for (int i = 0; i < 12; i++) d[i*32 +: 32] = c[i];
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        hit_queue.push_back(predict_slab(c));
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom);
            1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            2: return 0;
            default: return coord_t'($urandom_range(40 << 16)) - coord_t'(20 << 16);
        endcase
    endfunction

    function automatic coord_t pick_dir();
        case ($urandom_range(7))
            0: return 0;
            1: return coord_t'($urandom);
            2: return $urandom_range(1) ? 32'sh00000001 : 32'shFFFFFFFF;
            default: return coord_t'($urandom_range(4 << 16)) - coord_t'(2 << 16);
        endcase
    endfunction

    task automatic send_random(int n);
        coord_t c[12];
        coord_t lo, hi;
        for (int k = 0; k < n; k++) begin
            for (int ax = 0; ax < 3; ax++) begin
                c[ax] = pick_coord();
                c[3+ax] = pick_dir();
                lo = pick_coord();
                hi = pick_coord();
                if ($urandom_range(9) != 0 && hi < lo) begin
                    c[6+ax] = hi;
                    c[9+ax] = lo;
                end else begin
                    c[6+ax] = lo;
                    c[9+ax] = hi;
                end
            end
            send_box(c);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 5) @(posedge aclk);
    endtask

    task automatic test_directed();
        coord_t c[12];
        // unit box, diagonal ray from outside
        c = '{-(2 << 16), -(2 << 16), -(2 << 16), 1 << 16, 1 << 16, 1 << 16,
              0, 0, 0, 1 << 16, 1 << 16, 1 << 16};
        send_box(c);
        // origin inside box, negative direction
        c = '{1 << 15, 1 << 15, 1 << 15, -(1 << 16), -(1 << 14), 3 << 16,
              0, 0, 0, 1 << 16, 1 << 16, 1 << 16};
        send_box(c);
        // parallel axis inside slab, all axes parallel
        c = '{1 << 15, 1 << 15, 1 << 15, 0, 0, 0, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16};
        send_box(c);
        // parallel axis outside slab
        c = '{5 << 16, 0, 0, 0, 1 << 16, 0, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16};
        send_box(c);
        // inverted box on a parallel axis
        c = '{0, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 0, 0, 0, 1 << 16, 1 << 16};
        send_box(c);
        // inverted box on a moving axis
        c = '{0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 3 << 16, 3 << 16, 3 << 16,
              1 << 16, 1 << 16, 1 << 16};
        send_box(c);
        // box behind the origin
        c = '{0, 0, 0, 1 << 16, 1 << 16, 1 << 16, -(3 << 16), -(3 << 16), -(3 << 16),
              -(1 << 16), -(1 << 16), -(1 << 16)};
        send_box(c);
        // touching at a corner edge
        c = '{0, 0, 0, 1 << 16, 0, 0, 1 << 16, 0, 0, 1 << 16, 0, 0};
        send_box(c);
        // extreme coordinates, tiny direction, saturation
        c = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 1, 1,
              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
        send_box(c);
        c = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
        send_box(c);
        c = '{-1, -1, -1, -1, -1, -1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              -1, -1, -1};
        send_box(c);
        // wait for every result before going on
        drain_results();
    endtask

    task automatic test_phase(int idle_pct, int stall_pct, int n);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        send_random(n);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        slab_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{hit: m_tdata[0], t_entry: m_tdata[31:1], t_exit: m_tdata[62:32]};
            if (hit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: %p", got);
            end else begin
                want = hit_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("ray_box_slab_intersect_top regression: fail");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_phase(0, 0, 450);
        test_phase(83, 0, 350);
        test_phase(0, 83, 350);
        test_phase(17, 17, 500);
        drain_results();
        if (mismatches == 0 && hit_queue.size() == 0) begin
            $display("ray_box_slab_intersect_top regression: pass");
        end else begin
            $display("ray_box_slab_intersect_top regression: fail");
        end
        $finish;
    end
endmodule
